[src/assert_macros.svh]
// Assertion macros shared by the RTL of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/erfc_pkg.sv]
package erfc_pkg;

    // Width of the saturating byte counter.
    localparam int COUNT_BITS = 11;

    // Fixed frame layout values.
    localparam logic [7:0]  PREAMBLE_BYTE  = 8'h55;
    localparam logic [7:0]  SFD_BYTE       = 8'hd5;
    localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
    localparam int          OVERHEAD_BYTES = 12;

    // Register reset values.
    localparam logic [10:0] MIN_FRAME_RESET = 11'd64;
    localparam logic [10:0] MAX_FRAME_RESET = 11'd1536;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MIN_FRAME = 2'd0,
        CFG_MAX_FRAME = 2'd1,
        CFG_CRC_SEED  = 2'd2,
        CFG_CRC_XOR   = 2'd3
    } t_cfg_index;

    // Frame status codes.
    typedef enum logic [2:0] {
        ST_GOOD     = 3'd0,
        ST_SHORT    = 3'd1,
        ST_LONG     = 3'd2,
        ST_PREAMBLE = 3'd3,
        ST_CRC      = 3'd4
    } t_status;

    // One received byte.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_rx_in;

    // One frame result.
    typedef struct packed {
        t_status     frame_status;
        logic [10:0] payload_length;
    } t_rx_out;

    // Reflected CRC-32 update over one byte, least significant bit first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[src/ethernet_rx_frame_checker.sv]
// A frame's result is registered into the head register, or into the skid register while a stalled head holds one.
// Throughput: one byte per cycle while o_in_stall is low; the byte-wide CRC update and the checks sit in one stage.
// A two-entry result queue lets input continue while one result waits to be taken.
// Reset (synchronous, active low) restores the register defaults and clears frame state.
module ethernet_rx_frame_checker
    import erfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_rx_in      i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_rx_out     o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

`include "assert_macros.svh"

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] OVERHEAD  = COUNT_BITS'(OVERHEAD_BYTES);
    localparam logic [COUNT_BITS-1:0] POS_SFD   = COUNT_BITS'(7);

    // Configuration registers.
    logic [10:0] r_min_frame;
    logic [10:0] r_max_frame;
    logic [31:0] r_crc_seed;
    logic [31:0] r_crc_xor;

    // Per-frame state.
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [31:0]           r_crc, n_crc;
    logic [31:0]           r_window, n_window;
    logic                  r_pre_good, n_pre_good;

    // Result queue: head register and skid register.
    logic    r_out_valid, r_skid_valid;
    t_rx_out r_out, r_skid;
    t_rx_out n_result;

    logic in_acc;
    logic out_take;
    logic push;
    logic [31:0] crc_cur;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_acc   = i_in_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_out_stall;
    assign push     = in_acc && i_in_data.last_byte;

    // Next frame state and the result for a final byte.
    always_comb begin
        crc_cur    = (r_count == '0) ? r_crc_seed : r_crc;
        n_pre_good = r_pre_good;
        if (r_count < POS_SFD) begin
            if (i_in_data.data_byte != PREAMBLE_BYTE) n_pre_good = 1'b0;
        end else if (r_count == POS_SFD) begin
            if (i_in_data.data_byte != SFD_BYTE) n_pre_good = 1'b0;
        end

        // The byte leaving the window is payload once twelve bytes have arrived.
        n_crc    = (r_count >= OVERHEAD) ? crc_byte(crc_cur, r_window[7:0]) : crc_cur;
        n_window = {i_in_data.data_byte, r_window[31:8]};
        n_count  = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;

        n_result.payload_length = '0;
        if (n_count < OVERHEAD || n_count < COUNT_BITS'(r_min_frame)) begin
            n_result.frame_status = ST_SHORT;
        end else if (n_count > COUNT_BITS'(r_max_frame)) begin
            n_result.frame_status = ST_LONG;
        end else if (!n_pre_good) begin
            n_result.frame_status = ST_PREAMBLE;
        end else if ((n_crc ^ r_crc_xor) != n_window) begin
            n_result.frame_status = ST_CRC;
        end else begin
            n_result.frame_status   = ST_GOOD;
            n_result.payload_length = 11'(n_count - OVERHEAD);
        end
    end

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_frame <= MIN_FRAME_RESET;
            r_max_frame <= MAX_FRAME_RESET;
            r_crc_seed  <= '0;
            r_crc_xor   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MIN_FRAME: r_min_frame <= i_cfg_data[10:0];
                CFG_MAX_FRAME: r_max_frame <= i_cfg_data[10:0];
                CFG_CRC_SEED:  r_crc_seed  <= i_cfg_data;
                CFG_CRC_XOR:   r_crc_xor   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame state update; a final byte clears it for the next frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_crc      <= '0;
            r_window   <= '0;
            r_pre_good <= 1'b1;
        end else if (in_acc) begin
            if (i_in_data.last_byte) begin
                r_count    <= '0;
                r_crc      <= r_crc_seed;
                r_window   <= '0;
                r_pre_good <= 1'b1;
            end else begin
                r_count    <= n_count;
                r_crc      <= n_crc;
                r_window   <= n_window;
                r_pre_good <= n_pre_good;
            end
        end
    end

    // Result queue control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= push;
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Result queue data.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) r_out <= r_skid;
        end else if (!r_out_valid || out_take) begin
            if (push) r_out <= n_result;
        end else if (push) begin
            r_skid <= n_result;
        end
    end

    `ASSERT_CLK(a_skid_behind_head, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid entry without head entry")
    `ASSERT_CLK(a_bad_has_no_length, i_clk, i_rst_n, (r_out_valid && r_out.frame_status != ST_GOOD) |-> (r_out.payload_length == '0), "failed frame carries a length")
    `ASSERT_CLK(a_last_clears_count, i_clk, i_rst_n, push |=> (r_count == '0), "byte count not cleared after final byte")
    `ASSERT_CLK(a_blocked_result_kept, i_clk, i_rst_n, (push && r_out_valid && i_out_stall) |=> r_skid_valid, "result lost while head is stalled")

endmodule
